// ===== hw/rtl/tfim_pkg.sv =====
`default_nettype none

package tfim_pkg;

	// Field widths of one input word and one result word.
	localparam int OPCODE_W  = 2;
	localparam int QSEL_W    = 2;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;
	localparam int MOVED_W   = 6;

	// Number of queues sharing the store.
	localparam int NUM_QUEUES = 3;

	typedef logic [OPCODE_W-1:0] opcode_t;
	typedef logic [QSEL_W-1:0]   qsel_t;
	typedef logic [DATA_W-1:0]   data_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [MOVED_W-1:0]  moved_t;

	// Operation codes.
	localparam opcode_t OP_ENQ   = 2'd0;
	localparam opcode_t OP_DEQ   = 2'd1;
	localparam opcode_t OP_MERGE = 2'd2;

	// Result status codes.
	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/tfim_in_if.sv =====
`default_nettype none

// Request channel: one operation per word.
interface tfim_in_if;
	logic              valid;
	logic              ready;
	tfim_pkg::opcode_t opcode;
	tfim_pkg::qsel_t   queue_select;
	tfim_pkg::data_t   push_word;

	modport source (output valid, opcode, queue_select, push_word, input ready);
	modport sink   (input valid, opcode, queue_select, push_word, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tfim_out_if.sv =====
`default_nettype none

// Response channel: one result word per request word.
interface tfim_out_if;
	logic              valid;
	logic              ready;
	tfim_pkg::status_t status;
	tfim_pkg::data_t   pop_word;
	tfim_pkg::moved_t  moved_count;

	modport source (output valid, status, pop_word, moved_count, input ready);
	modport sink   (input valid, status, pop_word, moved_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tfim_store.sv =====
`default_nettype none

// Shared word store: one write port, one read port with registered read data.
module tfim_store #(
	parameter int ENTRIES = 48,
	parameter int AW      = 6
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire tfim_pkg::data_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output tfim_pkg::data_t      rdata
);

	tfim_pkg::data_t mem [ENTRIES];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/triple_fifo_interleave_merge_core.sv =====
// Results: enqueue and rejected operations register their result word on acceptance; a dequeue
// registers it from the ST_POP state after its store read; a merge once both sources are empty
// or queue 2 is full. Throughput: one operation at a time; a merge holds off requests while it runs,
// one source visited per cycle, plus any wait for the previous result word to be taken.
// Reset: arst_n clears all queue pointers and fill counts at once; the store itself
// is not cleared, since an entry is only read after it was written.
`default_nettype none

module triple_fifo_interleave_merge_core #(
	parameter int DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tfim_in_if.sink    req,
	tfim_out_if.source rsp
);

	localparam int ENTRIES = tfim_pkg::NUM_QUEUES * DEPTH;
	localparam int AW      = $clog2(ENTRIES);
	localparam int IW      = $clog2(DEPTH);
	localparam int CW      = $clog2(DEPTH + 1);

	localparam logic [AW-1:0] BASE1 = AW'(DEPTH);
	localparam logic [AW-1:0] BASE2 = AW'(2 * DEPTH);
	localparam logic [IW-1:0] IDX_LAST = IW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_POP   = 2'd1;
	localparam logic [1:0] ST_MERGE = 2'd2;

	logic [1:0]    state_q;
	logic [IW-1:0] head_q [tfim_pkg::NUM_QUEUES];
	logic [IW-1:0] tail_q [tfim_pkg::NUM_QUEUES];
	logic [CW-1:0] cnt_q  [tfim_pkg::NUM_QUEUES];
	logic          src_q;
	tfim_pkg::moved_t moved_q;

	// Pending merge write into queue 2, issued in the cycle after its read.
	logic          mv_pend_s1;
	logic [AW-1:0] mv_waddr_s1;

	logic              rsp_valid_q;
	tfim_pkg::status_t status_q;
	tfim_pkg::data_t   pop_word_q;
	tfim_pkg::moved_t  moved_count_q;

	logic            acc;
	logic            sel_ok;
	tfim_pkg::qsel_t q_idx;
	logic [IW-1:0]   head_cur;
	logic [IW-1:0]   tail_cur;
	logic [CW-1:0]   cnt_cur;
	logic            enq_go;
	logic            deq_go;
	logic [CW-1:0]   cnt_oth;
	logic            q2_full;
	logic            mv_go;
	logic            mv_end_ok;
	logic            mv_end_full;
	logic            we;
	logic [AW-1:0]   waddr;
	tfim_pkg::data_t wdata;
	logic [AW-1:0]   raddr;
	tfim_pkg::data_t rdata;

	function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
		return (i == IDX_LAST) ? '0 : i + IW'(1);
	endfunction

	function automatic logic [AW-1:0] q_base(input tfim_pkg::qsel_t q);
		return q[1] ? BASE2 : (q[0] ? BASE1 : '0);
	endfunction

	// Handshake and queue selection; a merge addresses its current source queue.
	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign sel_ok    = req.queue_select < tfim_pkg::QSEL_W'(tfim_pkg::NUM_QUEUES);
	assign q_idx     = (state_q == ST_MERGE) ? {1'b0, src_q} : req.queue_select;
	assign head_cur  = head_q[q_idx];
	assign tail_cur  = tail_q[q_idx];
	assign cnt_cur   = cnt_q[q_idx];

	assign enq_go = acc && (req.opcode == tfim_pkg::OP_ENQ) && sel_ok && (cnt_cur != CNT_FULL);
	assign deq_go = acc && (req.opcode == tfim_pkg::OP_DEQ) && sel_ok && (cnt_cur != '0);

	// Merge step decisions for the current source queue.
	assign cnt_oth     = src_q ? cnt_q[0] : cnt_q[1];
	assign q2_full     = (cnt_q[2] == CNT_FULL);
	assign mv_go       = (state_q == ST_MERGE) && (cnt_cur != '0) && !q2_full;
	assign mv_end_ok   = (state_q == ST_MERGE) && (cnt_cur == '0) && (cnt_oth == '0);
	assign mv_end_full = (state_q == ST_MERGE) && (cnt_cur != '0) && q2_full;

	// Store port muxing: enqueue writes directly, a merge writes the word read last cycle.
	always_comb begin
		if (mv_pend_s1) begin
			we    = 1'b1;
			waddr = mv_waddr_s1;
			wdata = rdata;
		end else begin
			we    = enq_go;
			waddr = q_base(q_idx) + AW'(tail_cur);
			wdata = req.push_word;
		end
	end
	assign raddr = q_base(q_idx) + AW'(head_cur);

	tfim_store #(
		.ENTRIES(ENTRIES),
		.AW     (AW)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Sequencer state, merge source and moved count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			src_q      <= 1'b0;
			moved_q    <= '0;
			mv_pend_s1 <= 1'b0;
		end else begin
			mv_pend_s1 <= mv_go;
			case (state_q)
				ST_IDLE: begin
					if (deq_go) begin
						state_q <= ST_POP;
					end else if (acc && (req.opcode == tfim_pkg::OP_MERGE)) begin
						state_q <= ST_MERGE;
						src_q   <= 1'b0;
						moved_q <= '0;
					end
				end
				ST_POP: begin
					state_q <= ST_IDLE;
				end
				ST_MERGE: begin
					if (mv_end_ok || mv_end_full) begin
						state_q <= ST_IDLE;
					end else if (mv_go) begin
						src_q   <= ~src_q;
						moved_q <= moved_q + tfim_pkg::MOVED_W'(1);
					end else begin
						// Current source empty, the other still holds words.
						src_q <= ~src_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Write address of a merge move, paired with the read issued this cycle.
	always_ff @(posedge clk) begin
		if (mv_go) begin
			mv_waddr_s1 <= BASE2 + AW'(tail_q[2]);
		end
	end

	// Queue pointers and fill counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tfim_pkg::NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (enq_go) begin
				tail_q[q_idx] <= ring_next(tail_cur);
				cnt_q[q_idx]  <= cnt_cur + CW'(1);
			end
			if (deq_go) begin
				head_q[q_idx] <= ring_next(head_cur);
				cnt_q[q_idx]  <= cnt_cur - CW'(1);
			end
			if (mv_go) begin
				head_q[q_idx] <= ring_next(head_cur);
				cnt_q[q_idx]  <= cnt_cur - CW'(1);
				tail_q[2]     <= ring_next(tail_q[2]);
				cnt_q[2]      <= cnt_q[2] + CW'(1);
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if ((acc && !deq_go && (req.opcode != tfim_pkg::OP_MERGE)) ||
			    (state_q == ST_POP) || mv_end_ok || mv_end_full) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !deq_go && (req.opcode != tfim_pkg::OP_MERGE)) begin
			pop_word_q    <= '0;
			moved_count_q <= '0;
			if ((req.opcode == tfim_pkg::OP_ENQ) && sel_ok && !enq_go) begin
				status_q <= tfim_pkg::STATUS_FULL;
			end else if ((req.opcode == tfim_pkg::OP_DEQ) && sel_ok) begin
				status_q <= tfim_pkg::STATUS_EMPTY;
			end else begin
				status_q <= tfim_pkg::STATUS_OK;
			end
		end else if (state_q == ST_POP) begin
			status_q      <= tfim_pkg::STATUS_OK;
			pop_word_q    <= rdata;
			moved_count_q <= '0;
		end else if (mv_end_ok || mv_end_full) begin
			status_q      <= mv_end_full ? tfim_pkg::STATUS_FULL : tfim_pkg::STATUS_OK;
			pop_word_q    <= '0;
			moved_count_q <= moved_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.pop_word    = pop_word_q;
	assign rsp.moved_count = moved_count_q;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 2000;
	localparam int PHASE_ITEMS = 250;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

	// Codes that the package leaves unnamed.
	localparam tfim_pkg::opcode_t OP_NOP = 2'd3;
	localparam tfim_pkg::qsel_t QSEL_NONE = 2'd3;

	// Queue roles in a merge.
	localparam int SRC_A = 0;
	localparam int SRC_B = 1;
	localparam int DST = 2;

	// Outcome of moving one word during a merge.
	typedef enum int {MOVE_SRC_EMPTY, MOVE_DONE, MOVE_DST_FULL} move_t;

	typedef struct packed {
		tfim_pkg::opcode_t opcode;
		tfim_pkg::qsel_t   queue_select;
		tfim_pkg::data_t   push_word;
	} request_t;

	typedef struct packed {
		tfim_pkg::status_t status;
		tfim_pkg::data_t   pop_word;
		tfim_pkg::moved_t  moved_count;
	} result_t;

	// Mirror of the three rings and the results they should produce.
	class fifo_merge_scoreboard;
		tfim_pkg::data_t store[tfim_pkg::NUM_QUEUES*DEPTH];
		int unsigned head[tfim_pkg::NUM_QUEUES];
		int unsigned tail[tfim_pkg::NUM_QUEUES];
		int unsigned fill[tfim_pkg::NUM_QUEUES];
		result_t expected_q[$];
		int unsigned error_count;

		function new();
			foreach (store[i]) store[i] = '0;
			foreach (fill[i]) begin
				head[i] = 0;
				tail[i] = 0;
				fill[i] = 0;
			end
			error_count = 0;
		endfunction

		function int unsigned ring_next(int unsigned i);
			return (i + 1 >= DEPTH) ? 0 : i + 1;
		endfunction

		function bit push(int unsigned q, tfim_pkg::data_t w);
			if (fill[q] >= DEPTH) return 1'b0;
			store[q*DEPTH + tail[q]] = w;
			tail[q] = ring_next(tail[q]);
			fill[q]++;
			return 1'b1;
		endfunction

		function bit pop(int unsigned q, output tfim_pkg::data_t w);
			w = '0;
			if (fill[q] == 0) return 1'b0;
			w = store[q*DEPTH + head[q]];
			head[q] = ring_next(head[q]);
			fill[q]--;
			return 1'b1;
		endfunction

		function move_t move_one(int unsigned src);
			tfim_pkg::data_t w;
			bit ok;
			if (fill[src] == 0) return MOVE_SRC_EMPTY;
			if (fill[DST] >= DEPTH) return MOVE_DST_FULL;
			ok = pop(src, w);
			ok = push(DST, w);
			return MOVE_DONE;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Called for every accepted request word.
		function void note_request(request_t r);
			result_t e;
			bit any;
			move_t ma, mb;
			int unsigned moved;
			tfim_pkg::data_t w;
			e = '0;
			moved = 0;
			case (r.opcode)
				tfim_pkg::OP_ENQ: begin
					if (r.queue_select != QSEL_NONE && !push(r.queue_select, r.push_word))
						e.status = tfim_pkg::STATUS_FULL;
				end
				tfim_pkg::OP_DEQ: begin
					if (r.queue_select != QSEL_NONE) begin
						if (pop(r.queue_select, w)) e.pop_word = w;
						else e.status = tfim_pkg::STATUS_EMPTY;
					end
				end
				tfim_pkg::OP_MERGE: begin
					any = 1'b1;
					while (any) begin
						any = 1'b0;
						ma = move_one(SRC_A);
						if (ma == MOVE_DST_FULL) begin
							e.status = tfim_pkg::STATUS_FULL;
							break;
						end
						if (ma == MOVE_DONE) begin
							moved++;
							any = 1'b1;
						end
						mb = move_one(SRC_B);
						if (mb == MOVE_DST_FULL) begin
							e.status = tfim_pkg::STATUS_FULL;
							break;
						end
						if (mb == MOVE_DONE) begin
							moved++;
							any = 1'b1;
						end
					end
					e.moved_count = tfim_pkg::moved_t'(moved);
				end
				default: ;
			endcase
			expected_q.push_back(e);
		endfunction

		task report(string msg);
			error_count++;
			$display("mismatch at %0t: %s", $time, msg);
		endtask

		// Called for every accepted result word.
		task check_result(result_t got);
			result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result status=%0d pop=%h moved=%0d",
					got.status, got.pop_word, got.moved_count));
			end else begin
				e = expected_q.pop_front();
				if (got.status !== e.status)
					report($sformatf("status got %0d want %0d", got.status, e.status));
				if (got.pop_word !== e.pop_word)
					report($sformatf("pop_word got %h want %h", got.pop_word, e.pop_word));
				if (got.moved_count !== e.moved_count)
					report($sformatf("moved_count got %0d want %0d",
						got.moved_count, e.moved_count));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned counted_items;
	fifo_merge_scoreboard sb;

	tfim_in_if req_ch ();
	tfim_out_if rsp_ch ();

	triple_fifo_interleave_merge_core #(.DEPTH(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Clock and cycle counter.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog for a hung run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// Receiver stalls are redrawn at each falling edge.
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every accepted result word goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result('{rsp_ch.status, rsp_ch.pop_word, rsp_ch.moved_count});
	end

	// Float patterns and edge values show up more often than pure noise would give.
	function automatic tfim_pkg::data_t pick_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FC0_0000;
			3: return 32'h8000_0000;
			4: return 32'h3F80_0000;
			default: return $urandom;
		endcase
	endfunction

	// Idling follows the phase that the item count has reached.
	function automatic void set_phase();
		case ((counted_items / PHASE_ITEMS) % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 59;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 59;
			end
			default: begin
				send_idle_pct = 32;
				recv_stall_pct = 32;
			end
		endcase
	endfunction

	// Presents one request word from a falling edge until it is accepted.
	task automatic send_op(tfim_pkg::opcode_t op, tfim_pkg::qsel_t sel, tfim_pkg::data_t w);
		request_t r;
		r = '{op, sel, w};
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.opcode = op;
		req_ch.queue_select = sel;
		req_ch.push_word = w;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.note_request(r);
		if (op != OP_NOP && (op == tfim_pkg::OP_MERGE || sel != QSEL_NONE))
			counted_items++;
		@(negedge clk);
	endtask

	task automatic enqueue_burst(tfim_pkg::qsel_t sel, int unsigned n);
		repeat (n) send_op(tfim_pkg::OP_ENQ, sel, pick_word());
	endtask

	task automatic dequeue_burst(tfim_pkg::qsel_t sel, int unsigned n);
		repeat (n) send_op(tfim_pkg::OP_DEQ, sel, $urandom);
	endtask

	// Fills the sources and sometimes the destination, merges once or twice, then may drain the destination.
	task automatic merge_scenario();
		enqueue_burst(tfim_pkg::qsel_t'(SRC_A), $urandom_range(DEPTH));
		enqueue_burst(tfim_pkg::qsel_t'(SRC_B), $urandom_range(DEPTH));
		if ($urandom_range(1)) enqueue_burst(tfim_pkg::qsel_t'(DST), $urandom_range(DEPTH));
		send_op(tfim_pkg::OP_MERGE, tfim_pkg::qsel_t'($urandom_range(3)), $urandom);
		if ($urandom_range(2) == 0)
			send_op(tfim_pkg::OP_MERGE, tfim_pkg::qsel_t'($urandom_range(3)), $urandom);
		if ($urandom_range(1))
			dequeue_burst(tfim_pkg::qsel_t'(DST), $urandom_range(DEPTH + 1));
	endtask

	// Main stimulus.
	initial begin
		sb = new();
		cycle_count = 0;
		counted_items = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		req_ch.valid = 1'b0;
		req_ch.opcode = tfim_pkg::OP_ENQ;
		req_ch.queue_select = '0;
		req_ch.push_word = '0;
		arst_n = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty queues, ignored codes, extreme words and merge order.
		dequeue_burst(tfim_pkg::qsel_t'(SRC_A), 1);
		dequeue_burst(tfim_pkg::qsel_t'(SRC_B), 1);
		dequeue_burst(tfim_pkg::qsel_t'(DST), 1);
		send_op(tfim_pkg::OP_ENQ, QSEL_NONE, 32'hFFFF_FFFF);
		send_op(tfim_pkg::OP_DEQ, QSEL_NONE, 32'h0);
		send_op(OP_NOP, QSEL_NONE, 32'hFFFF_FFFF);
		send_op(tfim_pkg::OP_MERGE, '0, 32'h0);
		send_op(tfim_pkg::OP_ENQ, tfim_pkg::qsel_t'(SRC_A), 32'h0000_0000);
		send_op(tfim_pkg::OP_ENQ, tfim_pkg::qsel_t'(SRC_A), 32'hFFFF_FFFF);
		send_op(tfim_pkg::OP_ENQ, tfim_pkg::qsel_t'(SRC_B), 32'h8000_0000);
		send_op(tfim_pkg::OP_ENQ, tfim_pkg::qsel_t'(SRC_B), 32'h7FFF_FFFF);
		send_op(tfim_pkg::OP_ENQ, tfim_pkg::qsel_t'(SRC_B), 32'h7F80_0000);
		send_op(tfim_pkg::OP_MERGE, QSEL_NONE, 32'hFFFF_FFFF);
		dequeue_burst(tfim_pkg::qsel_t'(DST), 6);
		send_op(tfim_pkg::OP_ENQ, tfim_pkg::qsel_t'(DST), 32'h5555_5555);
		send_op(tfim_pkg::OP_ENQ, tfim_pkg::qsel_t'(DST), 32'hAAAA_AAAA);
		dequeue_burst(tfim_pkg::qsel_t'(DST), 2);

		// Random: mostly structured fill, merge and drain sequences.
		counted_items = 0;
		while (counted_items < RANDOM_ITEMS) begin
			set_phase();
			case ($urandom_range(19))
				0, 1, 2: send_op(tfim_pkg::opcode_t'($urandom_range(3)),
					tfim_pkg::qsel_t'($urandom_range(3)), $urandom);
				3, 4, 5, 6: enqueue_burst(tfim_pkg::qsel_t'($urandom_range(2)),
					$urandom_range(1, DEPTH + 3));
				7, 8, 9: dequeue_burst(tfim_pkg::qsel_t'($urandom_range(2)),
					$urandom_range(1, DEPTH + 3));
				10, 11, 12, 13, 14, 15, 16: merge_scenario();
				default: begin
					dequeue_burst(tfim_pkg::qsel_t'(SRC_A), DEPTH + 1);
					dequeue_burst(tfim_pkg::qsel_t'(SRC_B), DEPTH + 1);
					dequeue_burst(tfim_pkg::qsel_t'(DST), DEPTH + 1);
				end
			endcase
		end
		req_ch.valid = 1'b0;

		// Drain the outstanding results, then watch for strays.
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

`default_nettype wire
